// ===== rtl/coalescing_drop_oldest_fifo_unit_macros.svh =====
// assertion macros shared by the checker of the coalescing event fifo
// the macros refer to clk and rst_n of the module that uses them
`ifndef COALESCING_DROP_OLDEST_FIFO_UNIT_MACROS_SVH
`define COALESCING_DROP_OLDEST_FIFO_UNIT_MACROS_SVH

// same-cycle implication, checked only outside reset
`define CDOF_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cdof assertion failed");

// next-cycle implication, checked only outside reset
`define CDOF_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cdof assertion failed");

`endif

// ===== rtl/cdof_pkg.sv =====
// types and codes of the coalescing drop-oldest event fifo
// no dependencies; used by the front, the back, the top level and the checker
package cdof_pkg;

    localparam int KIND_W    = 2;
    localparam int PAY_W     = 32;
    localparam int TYPE_W    = 16;
    localparam int KEY_W     = 16;
    localparam int CAP_IN_W  = 6;
    localparam int LEVEL_W   = 6;
    localparam int COUNTER_W = 32;

    // input kind codes
    localparam logic [KIND_W-1:0] KIND_PUSH     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_POP      = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TAKE_ALL = 2'd2;
    localparam logic [KIND_W-1:0] KIND_CLEAR    = 2'd3;

    typedef enum logic [1:0] {
        OP_PUSH,
        OP_POP,
        OP_TAKE_ALL,
        OP_CLEAR
    } op_t;

    typedef enum logic [2:0] {
        STATUS_APPENDED      = 3'd0,
        STATUS_APPENDED_DROP = 3'd1,
        STATUS_COALESCED     = 3'd2,
        STATUS_ENTRY         = 3'd3,
        STATUS_EMPTY         = 3'd4,
        STATUS_CLEARED       = 3'd5
    } status_t;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    typedef struct packed {
        op_t               op;
        logic [PAY_W-1:0]  payload;
        logic [TYPE_W-1:0] event_type;
        logic [KEY_W-1:0]  merge_key;
        logic              merge_enable;
    } cmd_t;

    typedef struct packed {
        status_t              status;
        logic [PAY_W-1:0]     out_payload;
        logic [TYPE_W-1:0]    out_type;
        logic [KEY_W-1:0]     out_key;
        logic                 out_key_enable;
        logic                 last;
        logic [LEVEL_W-1:0]   level;
        logic [COUNTER_W-1:0] dropped_total;
        logic [COUNTER_W-1:0] merged_total;
    } result_t;

endpackage

// ===== rtl/cdof_front.sv =====
// front end of the event fifo: accepts input beats, decodes the kind
// and holds the decoded commands in a two-entry queue; uses cdof_pkg
module cdof_front
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [cdof_pkg::KIND_W-1:0]  kind,
    input  logic [cdof_pkg::PAY_W-1:0]   payload,
    input  logic [cdof_pkg::TYPE_W-1:0]  event_type,
    input  logic [cdof_pkg::KEY_W-1:0]   merge_key,
    input  logic                         merge_enable,
    output logic                         cmd_valid,
    output cdof_pkg::cmd_t               cmd,
    input  logic                         cmd_pop
);

    localparam int QD = 2;

    cdof_pkg::cmd_t  queue_mem [QD];
    cdof_pkg::cmd_t  cmd_in;
    logic            wr_ptr_reg;
    logic            wr_ptr_next;
    logic            rd_ptr_reg;
    logic            rd_ptr_next;
    logic [1:0]      fill_reg;
    logic [1:0]      fill_next;
    logic            push;
    logic            pop;

    always_comb
    begin
        cmd_in.payload      = payload;
        cmd_in.event_type   = event_type;
        cmd_in.merge_key    = merge_key;
        cmd_in.merge_enable = merge_enable;
        case (kind)
            cdof_pkg::KIND_PUSH:     cmd_in.op = cdof_pkg::OP_PUSH;
            cdof_pkg::KIND_POP:      cmd_in.op = cdof_pkg::OP_POP;
            cdof_pkg::KIND_TAKE_ALL: cmd_in.op = cdof_pkg::OP_TAKE_ALL;
            cdof_pkg::KIND_CLEAR:    cmd_in.op = cdof_pkg::OP_CLEAR;
            default:                 cmd_in.op = cdof_pkg::OP_CLEAR;
        endcase
    end

    assign in_ready  = (fill_reg != 2'(QD));
    assign cmd_valid = (fill_reg != 2'd0);
    assign cmd       = queue_mem[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = cmd_pop && cmd_valid;

    always_comb
    begin
        // two entries, so the pointers just toggle
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_mem[wr_ptr_reg] <= cmd_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

// ===== rtl/cdof_back.sv =====
// back end of the event fifo: entry store, ring pointers, counters and the
// sequencer that carries out one command, with the result output register
// uses cdof_pkg; commands come from cdof_front
module cdof_back
#(
    parameter int DEPTH        = 32,
    parameter int PAYLOAD_BITS = 32
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write_enable,
    input  logic [cdof_pkg::CAP_IN_W-1:0]    cfg_write_data,
    input  logic                             cmd_valid,
    input  cdof_pkg::cmd_t                   cmd,
    output logic                             cmd_pop,
    output logic                             out_valid,
    input  logic                             out_ready,
    output cdof_pkg::result_t                result
);

    localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int CAP_W      = (CNT_W > cdof_pkg::CAP_IN_W) ? CNT_W : cdof_pkg::CAP_IN_W;
    localparam int STORE_BITS = (PAYLOAD_BITS < cdof_pkg::PAY_W) ? PAYLOAD_BITS
                                                                 : cdof_pkg::PAY_W;
    localparam int TYPE_LO    = STORE_BITS;
    localparam int KEY_LO     = TYPE_LO + cdof_pkg::TYPE_W;
    localparam int KEN_BIT    = KEY_LO + cdof_pkg::KEY_W;
    localparam int ENTRY_W    = KEN_BIT + 1;
    localparam int LW         = cdof_pkg::LEVEL_W;
    localparam int CW         = cdof_pkg::COUNTER_W;
    localparam int PW         = cdof_pkg::PAY_W;

    // entry layout: {key enable, key, type, payload}
    logic [ENTRY_W-1:0]       mem [DEPTH];
    logic [ENTRY_W-1:0]       rd_data_reg;
    logic                     rd_en;
    logic [IDX_W-1:0]         rd_addr;
    logic                     wr_en;
    logic [IDX_W-1:0]         wr_addr;
    logic [ENTRY_W-1:0]       wr_data;

    cdof_pkg::state_t         state_reg;
    cdof_pkg::state_t         state_next;
    cdof_pkg::cmd_t           cmd_reg;
    cdof_pkg::cmd_t           cmd_next;
    logic [IDX_W-1:0]         head_reg;
    logic [IDX_W-1:0]         head_next;
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic [CW-1:0]            dropped_reg;
    logic [CW-1:0]            dropped_next;
    logic [CW-1:0]            merged_reg;
    logic [CW-1:0]            merged_next;
    logic [CAP_W-1:0]         cap_reg;
    logic [IDX_W-1:0]         walk_idx_reg;
    logic [IDX_W-1:0]         walk_idx_next;
    logic [CNT_W-1:0]         walk_left_reg;
    logic [CNT_W-1:0]         walk_left_next;
    logic                     out_valid_reg;
    cdof_pkg::result_t        res_reg;
    cdof_pkg::result_t        res_next;
    logic                     load_res;

    logic                     out_free;
    logic [IDX_W-1:0]         tail;
    logic                     merge_hit;
    logic [CNT_W-1:0]         cap_eff;
    logic [CNT_W-1:0]         keep;
    logic [CNT_W-1:0]         drop;
    logic [CNT_W-1:0]         kept;
    logic [IDX_W-1:0]         trim_head;
    logic [IDX_W-1:0]         slot;
    logic [IDX_W-1:0]         walk_step;

    // ring index plus an offset of at most DEPTH, wrapped once
    function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] a,
                                                  input logic [CNT_W-1:0] b);
        logic [CNT_W:0] s;
        s = (CNT_W+1)'(a) + (CNT_W+1)'(b);
        if (s >= (CNT_W+1)'(DEPTH))
        begin
            s = s - (CNT_W+1)'(DEPTH);
        end
        return s[IDX_W-1:0];
    endfunction

    function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] a,
                                              input logic [CW-1:0] b);
        logic [CW:0] s;
        s = (CW+1)'(a) + (CW+1)'(b);
        return s[CW] ? {CW{1'b1}} : s[CW-1:0];
    endfunction

    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign result    = res_reg;

    always_comb
    begin
        tail = wrap_add(head_reg, (count_reg == '0) ? '0 : count_reg - 1'b1);

        merge_hit = cmd_reg.merge_enable && (count_reg != '0)
                    && (rd_data_reg[KEY_LO-1:TYPE_LO] == cmd_reg.event_type)
                    && (rd_data_reg[KEN_BIT-1:KEY_LO] == cmd_reg.merge_key)
                    && rd_data_reg[KEN_BIT];

        // lowered capacity trims here, on the next appending push
        cap_eff = (cap_reg >= CAP_W'(DEPTH)) ? CNT_W'(DEPTH) : CNT_W'(cap_reg);
        keep    = (cap_eff != '0) ? cap_eff - 1'b1 : '0;
        if (count_reg > keep)
        begin
            drop = count_reg - keep;
            kept = keep;
        end
        else
        begin
            drop = '0;
            kept = count_reg;
        end
        trim_head = wrap_add(head_reg, drop);
        slot      = wrap_add(trim_head, kept);
        walk_step = wrap_add(walk_idx_reg, CNT_W'(1));
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        dropped_next   = dropped_reg;
        merged_next    = merged_reg;
        walk_idx_next  = walk_idx_reg;
        walk_left_next = walk_left_reg;
        cmd_pop        = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = head_reg;
        wr_en          = 1'b0;
        wr_addr        = slot;
        wr_data        = {cmd_reg.merge_enable, cmd_reg.merge_key, cmd_reg.event_type,
                          cmd_reg.payload[STORE_BITS-1:0]};
        load_res       = 1'b0;

        res_next                = res_reg;
        res_next.out_payload    = '0;
        res_next.out_type       = '0;
        res_next.out_key        = '0;
        res_next.out_key_enable = 1'b0;
        res_next.last           = 1'b1;

        case (state_reg)
            cdof_pkg::ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    // fetch the tail for a push, the head for anything else
                    cmd_pop        = 1'b1;
                    cmd_next       = cmd;
                    rd_en          = 1'b1;
                    rd_addr        = (cmd.op == cdof_pkg::OP_PUSH) ? tail : head_reg;
                    walk_idx_next  = head_reg;
                    walk_left_next = count_reg;
                    state_next     = cdof_pkg::ST_EXEC;
                end
            end
            cdof_pkg::ST_EXEC:
            begin
                if (out_free)
                begin
                    load_res   = 1'b1;
                    state_next = cdof_pkg::ST_IDLE;
                    case (cmd_reg.op)
                        cdof_pkg::OP_PUSH:
                        begin
                            wr_en = 1'b1;
                            if (merge_hit)
                            begin
                                wr_addr         = tail;
                                wr_data         = {rd_data_reg[ENTRY_W-1:TYPE_LO],
                                                   cmd_reg.payload[STORE_BITS-1:0]};
                                merged_next     = sat_add(merged_reg, CW'(1));
                                res_next.status = cdof_pkg::STATUS_COALESCED;
                            end
                            else
                            begin
                                head_next       = trim_head;
                                count_next      = kept + 1'b1;
                                dropped_next    = sat_add(dropped_reg, CW'(drop));
                                res_next.status = (drop != '0)
                                                  ? cdof_pkg::STATUS_APPENDED_DROP
                                                  : cdof_pkg::STATUS_APPENDED;
                            end
                        end
                        cdof_pkg::OP_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                res_next.status = cdof_pkg::STATUS_EMPTY;
                            end
                            else
                            begin
                                count_next = count_reg - 1'b1;
                                head_next  = (count_reg == CNT_W'(1)) ? '0
                                             : wrap_add(head_reg, CNT_W'(1));
                                res_next.status         = cdof_pkg::STATUS_ENTRY;
                                res_next.out_payload    = PW'(rd_data_reg[STORE_BITS-1:0]);
                                res_next.out_type       = rd_data_reg[KEY_LO-1:TYPE_LO];
                                res_next.out_key        = rd_data_reg[KEN_BIT-1:KEY_LO];
                                res_next.out_key_enable = rd_data_reg[KEN_BIT];
                            end
                        end
                        cdof_pkg::OP_TAKE_ALL:
                        begin
                            if (walk_left_reg == '0)
                            begin
                                res_next.status = cdof_pkg::STATUS_EMPTY;
                            end
                            else
                            begin
                                // one entry per beat, next read issued alongside
                                count_next              = '0;
                                head_next               = '0;
                                walk_left_next          = walk_left_reg - 1'b1;
                                walk_idx_next           = walk_step;
                                res_next.status         = cdof_pkg::STATUS_ENTRY;
                                res_next.out_payload    = PW'(rd_data_reg[STORE_BITS-1:0]);
                                res_next.out_type       = rd_data_reg[KEY_LO-1:TYPE_LO];
                                res_next.out_key        = rd_data_reg[KEN_BIT-1:KEY_LO];
                                res_next.out_key_enable = rd_data_reg[KEN_BIT];
                                res_next.last           = (walk_left_reg == CNT_W'(1));
                                if (walk_left_reg != CNT_W'(1))
                                begin
                                    rd_en      = 1'b1;
                                    rd_addr    = walk_step;
                                    state_next = cdof_pkg::ST_EXEC;
                                end
                            end
                        end
                        cdof_pkg::OP_CLEAR:
                        begin
                            count_next      = '0;
                            head_next       = '0;
                            res_next.status = cdof_pkg::STATUS_CLEARED;
                        end
                        default:
                        begin
                            res_next.status = cdof_pkg::STATUS_CLEARED;
                        end
                    endcase
                    res_next.level         = LW'(count_next);
                    res_next.dropped_total = dropped_next;
                    res_next.merged_total  = merged_next;
                end
            end
            default:
            begin
                state_next = cdof_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        if (load_res)
        begin
            res_reg <= res_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cdof_pkg::ST_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            dropped_reg   <= '0;
            merged_reg    <= '0;
            cap_reg       <= CAP_W'(DEPTH);
            walk_idx_reg  <= '0;
            walk_left_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            dropped_reg   <= dropped_next;
            merged_reg    <= merged_next;
            walk_idx_reg  <= walk_idx_next;
            walk_left_reg <= walk_left_next;
            if (cfg_write_enable)
            begin
                cap_reg <= CAP_W'(cfg_write_data);
            end
            if (load_res)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// ===== rtl/coalescing_drop_oldest_fifo_unit.sv =====
// Event FIFO with drop-oldest overflow and tail coalescing. For a push, pop or
// clear the back end reads the tail or head from the store, then does the update
// and write once the result register is free; take-all returns one entry per
// cycle while the result register is free, from the single registered read port
// of the entry store. A two-entry command queue sits in front, so up to two
// further beats are taken while the back end works or the result register waits
// for out_ready. The store needs no clearing after reset: only written entries are used.
module coalescing_drop_oldest_fifo_unit
#(
    parameter int DEPTH        = 32,
    parameter int PAYLOAD_BITS = 32
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write_enable,
    input  logic [cdof_pkg::CAP_IN_W-1:0]     cfg_write_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [cdof_pkg::KIND_W-1:0]       kind,
    input  logic [cdof_pkg::PAY_W-1:0]        payload,
    input  logic [cdof_pkg::TYPE_W-1:0]       event_type,
    input  logic [cdof_pkg::KEY_W-1:0]        merge_key,
    input  logic                              merge_enable,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [2:0]                        status,
    output logic [cdof_pkg::PAY_W-1:0]        out_payload,
    output logic [cdof_pkg::TYPE_W-1:0]       out_type,
    output logic [cdof_pkg::KEY_W-1:0]        out_key,
    output logic                              out_key_enable,
    output logic                              last,
    output logic [cdof_pkg::LEVEL_W-1:0]      level,
    output logic [cdof_pkg::COUNTER_W-1:0]    dropped_total,
    output logic [cdof_pkg::COUNTER_W-1:0]    merged_total
);

    logic               cmd_valid;
    logic               cmd_pop;
    cdof_pkg::cmd_t     cmd;
    cdof_pkg::result_t  result;

    cdof_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .kind         (kind),
        .payload      (payload),
        .event_type   (event_type),
        .merge_key    (merge_key),
        .merge_enable (merge_enable),
        .cmd_valid    (cmd_valid),
        .cmd          (cmd),
        .cmd_pop      (cmd_pop)
    );

    cdof_back
    #(
        .DEPTH        (DEPTH),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    )
    u_back
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_enable (cfg_write_enable),
        .cfg_write_data   (cfg_write_data),
        .cmd_valid        (cmd_valid),
        .cmd              (cmd),
        .cmd_pop          (cmd_pop),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .result           (result)
    );

    assign status         = result.status;
    assign out_payload    = result.out_payload;
    assign out_type       = result.out_type;
    assign out_key        = result.out_key;
    assign out_key_enable = result.out_key_enable;
    assign last           = result.last;
    assign level          = result.level;
    assign dropped_total  = result.dropped_total;
    assign merged_total   = result.merged_total;

endmodule

// ===== rtl/cdof_checker.sv =====
// port-level checker of the event fifo result channel, bound to the top level
// uses cdof_pkg and the assertion macros header
`include "coalescing_drop_oldest_fifo_unit_macros.svh"

module cdof_checker
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              out_valid,
    input  logic                              out_ready,
    input  logic [2:0]                        status,
    input  logic [cdof_pkg::PAY_W-1:0]        out_payload,
    input  logic [cdof_pkg::TYPE_W-1:0]       out_type,
    input  logic [cdof_pkg::KEY_W-1:0]        out_key,
    input  logic                              out_key_enable,
    input  logic                              last,
    input  logic [cdof_pkg::LEVEL_W-1:0]      level,
    input  logic [cdof_pkg::COUNTER_W-1:0]    dropped_total,
    input  logic [cdof_pkg::COUNTER_W-1:0]    merged_total
);

    // a stalled result beat holds
    `CDOF_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(out_payload) && $stable(last) && $stable(level) && $stable(dropped_total) && $stable(merged_total))

    // only a returned entry carries entry fields
    `CDOF_ASSERT_IMP(a_fields_zero, out_valid && (status != cdof_pkg::STATUS_ENTRY), (out_payload == '0) && (out_type == '0) && (out_key == '0) && !out_key_enable)

    // empty and clear leave nothing behind and end their command
    `CDOF_ASSERT_IMP(a_empty_clear, out_valid && ((status == cdof_pkg::STATUS_EMPTY) || (status == cdof_pkg::STATUS_CLEARED)), last && (level == '0))

    // anything but a returned entry is a single-beat result
    `CDOF_ASSERT_IMP(a_single_last, out_valid && (status != cdof_pkg::STATUS_ENTRY), last)

endmodule

bind coalescing_drop_oldest_fifo_unit cdof_checker u_cdof_checker
(
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .out_payload    (out_payload),
    .out_type       (out_type),
    .out_key        (out_key),
    .out_key_enable (out_key_enable),
    .last           (last),
    .level          (level),
    .dropped_total  (dropped_total),
    .merged_total   (merged_total)
);

// ===== bench/tb_top.sv =====
// self-checking bench for the coalescing drop-oldest event fifo
// predicts every result beat from a local fifo model; needs cdof_pkg and the fifo unit
module tb_top;

    localparam int SLOTS = 32;

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_write_enable;
    logic [cdof_pkg::CAP_IN_W-1:0]  cfg_write_data;
    logic                           in_valid;
    logic                           in_ready;
    logic [cdof_pkg::KIND_W-1:0]    kind;
    logic [cdof_pkg::PAY_W-1:0]     payload;
    logic [cdof_pkg::TYPE_W-1:0]    event_type;
    logic [cdof_pkg::KEY_W-1:0]     merge_key;
    logic                           merge_enable;
    logic                           out_valid;
    logic                           out_ready;
    logic [2:0]                     status;
    logic [cdof_pkg::PAY_W-1:0]     out_payload;
    logic [cdof_pkg::TYPE_W-1:0]    out_type;
    logic [cdof_pkg::KEY_W-1:0]     out_key;
    logic                           out_key_enable;
    logic                           last;
    logic [cdof_pkg::LEVEL_W-1:0]   level;
    logic [cdof_pkg::COUNTER_W-1:0] dropped_total;
    logic [cdof_pkg::COUNTER_W-1:0] merged_total;

    int send_idle_pct;
    int recv_idle_pct;
    int error_count;

    // model of the event ring
    logic [cdof_pkg::PAY_W-1:0]     fifo_pay [SLOTS];
    logic [cdof_pkg::TYPE_W-1:0]    fifo_type [SLOTS];
    logic [cdof_pkg::KEY_W-1:0]     fifo_key [SLOTS];
    logic                           fifo_ken [SLOTS];
    int                             fifo_head;
    int                             fifo_count;
    logic [cdof_pkg::COUNTER_W-1:0] fifo_dropped;
    logic [cdof_pkg::COUNTER_W-1:0] fifo_merged;
    logic [cdof_pkg::CAP_IN_W-1:0]  fifo_capacity;
    cdof_pkg::result_t              pending_results[$];

    logic [cdof_pkg::TYPE_W-1:0]    recent_type;
    logic [cdof_pkg::KEY_W-1:0]     recent_key;

    coalescing_drop_oldest_fifo_unit u_dut
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_enable (cfg_write_enable),
        .cfg_write_data   (cfg_write_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .kind             (kind),
        .payload          (payload),
        .event_type       (event_type),
        .merge_key        (merge_key),
        .merge_enable     (merge_enable),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .status           (status),
        .out_payload      (out_payload),
        .out_type         (out_type),
        .out_key          (out_key),
        .out_key_enable   (out_key_enable),
        .last             (last),
        .level            (level),
        .dropped_total    (dropped_total),
        .merged_total     (merged_total)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic logic [cdof_pkg::COUNTER_W-1:0] sat_add32(
        logic [cdof_pkg::COUNTER_W-1:0] a, int b);
        logic [cdof_pkg::COUNTER_W:0] sum;
        sum = {1'b0, a} + b;
        return sum[cdof_pkg::COUNTER_W] ? '1 : sum[cdof_pkg::COUNTER_W-1:0];
    endfunction

    function automatic cdof_pkg::result_t make_result(cdof_pkg::status_t st, int slot,
                                                      logic is_last);
        cdof_pkg::result_t r;
        r = '0;
        r.status = st;
        if (slot >= 0)
        begin
            r.out_payload    = fifo_pay[slot];
            r.out_type       = fifo_type[slot];
            r.out_key        = fifo_key[slot];
            r.out_key_enable = fifo_ken[slot];
        end
        r.last          = is_last;
        r.level         = fifo_count[cdof_pkg::LEVEL_W-1:0];
        r.dropped_total = fifo_dropped;
        r.merged_total  = fifo_merged;
        return r;
    endfunction

    function automatic void queue_beat(cdof_pkg::result_t r);
        pending_results.insert(pending_results.size(), r);
    endfunction

    // advance the ring model by one accepted command and queue its result beats
    task automatic apply_command(logic [cdof_pkg::KIND_W-1:0] k,
                                 logic [cdof_pkg::PAY_W-1:0] p,
                                 logic [cdof_pkg::TYPE_W-1:0] t,
                                 logic [cdof_pkg::KEY_W-1:0] key, logic en);
        int tail;
        int keep;
        int drop;
        int slot;
        int n;
        int h;
        case (k)
            cdof_pkg::KIND_PUSH:
            begin
                tail = (fifo_head + fifo_count + SLOTS - 1) % SLOTS;
                if (en && fifo_count != 0 && fifo_ken[tail] === 1'b1
                    && fifo_type[tail] == t && fifo_key[tail] == key)
                begin
                    fifo_pay[tail] = p;
                    fifo_merged = sat_add32(fifo_merged, 1);
                    queue_beat(make_result(cdof_pkg::STATUS_COALESCED, -1, 1'b1));
                end
                else
                begin
                    // capacity of the store depth or more is limited to the store depth
                    if (fifo_capacity >= SLOTS)
                        keep = SLOTS - 1;
                    else
                        keep = (fifo_capacity > 0) ? fifo_capacity - 1 : 0;
                    drop = (fifo_count > keep) ? fifo_count - keep : 0;
                    fifo_head = (fifo_head + drop) % SLOTS;
                    fifo_count -= drop;
                    fifo_dropped = sat_add32(fifo_dropped, drop);
                    slot = (fifo_head + fifo_count) % SLOTS;
                    fifo_pay[slot]  = p;
                    fifo_type[slot] = t;
                    fifo_key[slot]  = key;
                    fifo_ken[slot]  = en;
                    fifo_count++;
                    queue_beat(make_result(
                        (drop != 0) ? cdof_pkg::STATUS_APPENDED_DROP
                                    : cdof_pkg::STATUS_APPENDED, -1, 1'b1));
                end
            end
            cdof_pkg::KIND_POP:
            begin
                if (fifo_count == 0)
                begin
                    queue_beat(make_result(cdof_pkg::STATUS_EMPTY, -1, 1'b1));
                end
                else
                begin
                    slot = fifo_head;
                    fifo_head = (fifo_head + 1) % SLOTS;
                    fifo_count--;
                    if (fifo_count == 0)
                        fifo_head = 0;
                    queue_beat(make_result(cdof_pkg::STATUS_ENTRY, slot, 1'b1));
                end
            end
            cdof_pkg::KIND_TAKE_ALL:
            begin
                if (fifo_count == 0)
                begin
                    queue_beat(make_result(cdof_pkg::STATUS_EMPTY, -1, 1'b1));
                end
                else
                begin
                    n = fifo_count;
                    h = fifo_head;
                    fifo_count = 0;
                    fifo_head = 0;
                    for (int i = 0; i < n; i++)
                        queue_beat(make_result(cdof_pkg::STATUS_ENTRY, (h + i) % SLOTS,
                                               i == n - 1));
                end
            end
            default:
            begin
                fifo_count = 0;
                fifo_head = 0;
                queue_beat(make_result(cdof_pkg::STATUS_CLEARED, -1, 1'b1));
            end
        endcase
    endtask

    task automatic compare_field(string name, logic [cdof_pkg::COUNTER_W-1:0] want_v,
                                 logic [cdof_pkg::COUNTER_W-1:0] got_v);
        if (got_v !== want_v)
        begin
            error_count++;
            $error("%s: expected 0x%0h, got 0x%0h", name, want_v, got_v);
        end
    endtask

    always @(posedge clk)
    begin : result_check
        cdof_pkg::result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                error_count++;
                $error("result beat with nothing expected: status %0d", status);
            end
            else
            begin
                want = pending_results.pop_front();
                compare_field("status", want.status, status);
                compare_field("out_payload", want.out_payload, out_payload);
                compare_field("out_type", want.out_type, out_type);
                compare_field("out_key", want.out_key, out_key);
                compare_field("out_key_enable", want.out_key_enable, out_key_enable);
                compare_field("last", want.last, last);
                compare_field("level", want.level, level);
                compare_field("dropped_total", want.dropped_total, dropped_total);
                compare_field("merged_total", want.merged_total, merged_total);
            end
        end
    end

    // called at a rising edge; returns at the edge where the beat is taken
    task automatic send_item(logic [cdof_pkg::KIND_W-1:0] k,
                             logic [cdof_pkg::PAY_W-1:0] p,
                             logic [cdof_pkg::TYPE_W-1:0] t,
                             logic [cdof_pkg::KEY_W-1:0] key, logic en);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        in_valid     <= 1'b1;
        kind         <= k;
        payload      <= p;
        event_type   <= t;
        merge_key    <= key;
        merge_enable <= en;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        apply_command(k, p, t, key, en);
    endtask

    // non-push commands carry random filler in the push fields
    task automatic send_op(logic [cdof_pkg::KIND_W-1:0] k);
        send_item(k, $urandom, cdof_pkg::TYPE_W'($urandom), cdof_pkg::KEY_W'($urandom),
                  1'($urandom));
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        // let the back end settle before touching the register
        repeat (6) @(posedge clk);
    endtask

    task automatic write_capacity(logic [cdof_pkg::CAP_IN_W-1:0] value);
        cfg_write_enable <= 1'b1;
        cfg_write_data   <= value;
        @(posedge clk);
        cfg_write_enable <= 1'b0;
        fifo_capacity = value;
    endtask

    task automatic test_empty_queue();
        send_op(cdof_pkg::KIND_POP);
        send_op(cdof_pkg::KIND_TAKE_ALL);
        send_op(cdof_pkg::KIND_CLEAR);
    endtask

    task automatic test_push_fields_and_merge();
        send_item(cdof_pkg::KIND_PUSH, '0, '0, '0, 1'b0);
        send_item(cdof_pkg::KIND_PUSH, '1, '1, '1, 1'b1);
        send_item(cdof_pkg::KIND_PUSH, 32'h5a5a_a5a5, '1, '1, 1'b1);
        // tail match but the new event does not allow merging
        send_item(cdof_pkg::KIND_PUSH, 32'h0000_1234, '1, '1, 1'b0);
        // tail holds merging disabled, so no merge either
        send_item(cdof_pkg::KIND_PUSH, 32'h0000_4321, '1, '1, 1'b1);
        send_item(cdof_pkg::KIND_PUSH, 32'h0000_7777, '1, 16'hfffe, 1'b1);
        send_item(cdof_pkg::KIND_PUSH, 32'h0000_8888, 16'hfffe, 16'hfffe, 1'b1);
        send_op(cdof_pkg::KIND_POP);
        send_op(cdof_pkg::KIND_TAKE_ALL);
        send_item(cdof_pkg::KIND_PUSH, 32'hdead_beef, 16'h00ff, 16'hff00, 1'b1);
        send_op(cdof_pkg::KIND_CLEAR);
        send_op(cdof_pkg::KIND_POP);
    endtask

    task automatic test_capacity_zero();
        wait_for_results();
        write_capacity('0);
        send_item(cdof_pkg::KIND_PUSH, 32'h0000_0011, 16'h0001, 16'h0001, 1'b1);
        send_item(cdof_pkg::KIND_PUSH, 32'h0000_0022, 16'h0002, 16'h0002, 1'b1);
        send_item(cdof_pkg::KIND_PUSH, 32'h0000_0033, 16'h0002, 16'h0002, 1'b1);
        send_op(cdof_pkg::KIND_POP);
    endtask

    task automatic test_lowered_capacity();
        wait_for_results();
        write_capacity('1);
        send_item(cdof_pkg::KIND_PUSH, 32'h0000_0101, 16'h0010, 16'h0001, 1'b1);
        send_item(cdof_pkg::KIND_PUSH, 32'h0000_0102, 16'h0010, 16'h0002, 1'b1);
        send_item(cdof_pkg::KIND_PUSH, 32'h0000_0103, 16'h0010, 16'h0003, 1'b1);
        wait_for_results();
        write_capacity(6'd2);
        // a merging push leaves the over-full queue alone
        send_item(cdof_pkg::KIND_PUSH, 32'h0000_0104, 16'h0010, 16'h0003, 1'b1);
        send_item(cdof_pkg::KIND_PUSH, 32'h0000_0105, 16'h0011, 16'h0003, 1'b1);
        send_op(cdof_pkg::KIND_TAKE_ALL);
    endtask

    task automatic test_full_store();
        wait_for_results();
        write_capacity(6'd40);
        send_op(cdof_pkg::KIND_CLEAR);
        // fill past the store depth with merging off
        repeat (SLOTS + 2)
            send_item(cdof_pkg::KIND_PUSH, $urandom, cdof_pkg::TYPE_W'($urandom),
                      cdof_pkg::KEY_W'($urandom), 1'b0);
        send_op(cdof_pkg::KIND_TAKE_ALL);
    endtask

    function automatic logic [cdof_pkg::CAP_IN_W-1:0] pick_capacity();
        case ($urandom_range(9))
            0:       return '0;
            1:       return cdof_pkg::CAP_IN_W'(SLOTS);
            2:       return '1;
            3:       return cdof_pkg::CAP_IN_W'($urandom_range(SLOTS + 1, 62));
            default: return cdof_pkg::CAP_IN_W'($urandom_range(1, 8));
        endcase
    endfunction

    task automatic send_random_command();
        int pick;
        logic [cdof_pkg::TYPE_W-1:0] t;
        logic [cdof_pkg::KEY_W-1:0] key;
        pick = $urandom_range(99);
        if (pick < 60)
        begin
            // repeat the recent type and key, or draw them from small sets, so merges happen
            case ($urandom_range(3))
                0:
                begin
                    t = recent_type;
                    key = recent_key;
                end
                1:
                begin
                    t = cdof_pkg::TYPE_W'($urandom_range(1));
                    key = cdof_pkg::KEY_W'($urandom_range(2));
                end
                2:
                begin
                    t = cdof_pkg::TYPE_W'($urandom);
                    key = cdof_pkg::KEY_W'($urandom);
                end
                default:
                begin
                    t = $urandom_range(1) ? '1 : '0;
                    key = $urandom_range(1) ? '1 : '0;
                end
            endcase
            recent_type = t;
            recent_key = key;
            send_item(cdof_pkg::KIND_PUSH, $urandom, t, key, $urandom_range(3) != 0);
        end
        else if (pick < 82)
            send_op(cdof_pkg::KIND_POP);
        else if (pick < 94)
            send_op(cdof_pkg::KIND_TAKE_ALL);
        else
            send_op(cdof_pkg::KIND_CLEAR);
    endtask

    task automatic test_random_traffic(int chunks, int per_chunk);
        for (int c = 0; c < chunks; c++)
        begin
            wait_for_results();
            write_capacity(pick_capacity());
            repeat (per_chunk)
                send_random_command();
        end
    endtask

    initial
    begin
        #20_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        clk              = 1'b0;
        rst_n            = 1'b0;
        cfg_write_enable = 1'b0;
        cfg_write_data   = '0;
        in_valid         = 1'b0;
        kind             = cdof_pkg::KIND_PUSH;
        payload          = '0;
        event_type       = '0;
        merge_key        = '0;
        merge_enable     = 1'b0;
        out_ready        = 1'b0;
        error_count      = 0;
        send_idle_pct    = 11;
        recv_idle_pct    = 85;
        recent_type      = '0;
        recent_key       = '0;
        fifo_head        = 0;
        fifo_count       = 0;
        fifo_dropped     = '0;
        fifo_merged      = '0;
        fifo_capacity    = cdof_pkg::CAP_IN_W'(SLOTS);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_queue();
        test_push_fields_and_merge();
        test_capacity_zero();
        test_lowered_capacity();
        test_random_traffic(3, 18);

        send_idle_pct = 85;
        recv_idle_pct = 11;
        test_full_store();
        test_random_traffic(3, 18);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(3, 18);

        wait_for_results();
        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
